// ===== rtl/sgd_pkg.sv =====
// Shared types, widths and constants of the Scharr gradient direction block.
// Used by every RTL module of the block and by its checker; depends on nothing.
`default_nettype none

package sgd_pkg;

    // Field widths.
    localparam int COORD_W  = 12;
    localparam int PIX_W    = 8;
    localparam int DIM_W    = 13;
    localparam int GRAD_W   = 13;
    localparam int DIR_W    = 16;
    localparam int CFG_IDX_W = 1;

    // CORDIC datapath: inputs are scaled up before the iterations start.
    localparam int CORDIC_STAGES = 14;
    localparam int CORDIC_W      = 32;
    localparam int PRESHIFT      = 16;
    localparam int ANG_W         = 17;

    // Angles in signed Q3.13 radians.
    localparam logic signed [ANG_W-1:0] ANG_PI      = 17'sd25736;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 17'sd12868;
    localparam logic signed [ANG_W-1:0] ANG_ZERO    = 17'sd0;

    // Reset values of the image size registers.
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Gradient word handed from the filter stage to the CORDIC.
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     border;
    } grad_word_t;

    // Angle word handed from the CORDIC to the output register.
    typedef struct packed {
        logic signed [ANG_W-1:0]  angle;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     border;
    } angle_word_t;

    // Arctangent of 2^-i in Q3.13, rounded; zero past the table end.
    function automatic logic signed [ANG_W-1:0] atan_q13(input int idx);
        logic signed [ANG_W-1:0] val;
        begin
            unique case (idx)
                0:       val = 17'sd6434;
                1:       val = 17'sd3798;
                2:       val = 17'sd2007;
                3:       val = 17'sd1019;
                4:       val = 17'sd511;
                5:       val = 17'sd256;
                6:       val = 17'sd128;
                7:       val = 17'sd64;
                8:       val = 17'sd32;
                9:       val = 17'sd16;
                10:      val = 17'sd8;
                11:      val = 17'sd4;
                12:      val = 17'sd2;
                13:      val = 17'sd1;
                default: val = 17'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sgd_grad.sv =====
// Gradient stage: forms the 3/10/3 horizontal and vertical gradients and the
// border flag in one register stage. Depends on sgd_pkg.
`default_nettype none

module sgd_grad (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [sgd_pkg::COORD_W-1:0]    x_coord,
    input  wire logic [sgd_pkg::COORD_W-1:0]    y_coord,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_top_left,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_top_mid,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_top_right,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_mid_left,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_mid_right,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_bot_left,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_bot_mid,
    input  wire logic [sgd_pkg::PIX_W-1:0]      pixel_bot_right,
    input  wire logic [sgd_pkg::DIM_W-1:0]      image_width,
    input  wire logic [sgd_pkg::DIM_W-1:0]      image_height,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output sgd_pkg::grad_word_t                 out_word
);
    import sgd_pkg::*;

    localparam int PAD_W = GRAD_W - PIX_W;

    logic signed [GRAD_W-1:0] d_gx_top;
    logic signed [GRAD_W-1:0] d_gx_mid;
    logic signed [GRAD_W-1:0] d_gx_bot;
    logic signed [GRAD_W-1:0] d_gy_left;
    logic signed [GRAD_W-1:0] d_gy_mid;
    logic signed [GRAD_W-1:0] d_gy_right;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [DIM_W-1:0]         x_plus;
    logic [DIM_W-1:0]         y_plus;
    logic                     border;
    logic                     valid_reg;
    grad_word_t               word_reg;
    grad_word_t               word_next;

    // Pixel differences, zero-extended before subtracting.
    always_comb
    begin
        d_gx_top   = $signed({{PAD_W{1'b0}}, pixel_top_right}) -
                     $signed({{PAD_W{1'b0}}, pixel_top_left});
        d_gx_mid   = $signed({{PAD_W{1'b0}}, pixel_mid_right}) -
                     $signed({{PAD_W{1'b0}}, pixel_mid_left});
        d_gx_bot   = $signed({{PAD_W{1'b0}}, pixel_bot_right}) -
                     $signed({{PAD_W{1'b0}}, pixel_bot_left});
        d_gy_left  = $signed({{PAD_W{1'b0}}, pixel_bot_left}) -
                     $signed({{PAD_W{1'b0}}, pixel_top_left});
        d_gy_mid   = $signed({{PAD_W{1'b0}}, pixel_bot_mid}) -
                     $signed({{PAD_W{1'b0}}, pixel_top_mid});
        d_gy_right = $signed({{PAD_W{1'b0}}, pixel_bot_right}) -
                     $signed({{PAD_W{1'b0}}, pixel_top_right});
    end

    // Weighted sums: 3 = 2 + 1 and 10 = 8 + 2, built from shifts.
    always_comb
    begin
        gx = (d_gx_top <<< 1) + d_gx_top + (d_gx_mid <<< 3) + (d_gx_mid <<< 1) +
             (d_gx_bot <<< 1) + d_gx_bot;
        gy = (d_gy_left <<< 1) + d_gy_left + (d_gy_mid <<< 3) + (d_gy_mid <<< 1) +
             (d_gy_right <<< 1) + d_gy_right;
    end

    // The window leaves the image on the first or last row or column.
    always_comb
    begin
        x_plus = {1'b0, x_coord} + DIM_W'(1);
        y_plus = {1'b0, y_coord} + DIM_W'(1);
        border = (x_coord == '0) || (y_coord == '0) ||
                 (x_plus >= image_width) || (y_plus >= image_height);
        word_next.border = border;
        word_next.gx     = border ? '0 : gx;
        word_next.gy     = border ? '0 : gy;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // Stage register; it refills whenever it is empty or drains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sgd_cordic.sv =====
// Pipelined vectoring CORDIC: one setup stage, then one register stage per
// iteration, each with its own valid bit. Depends on sgd_pkg.
`default_nettype none

module sgd_cordic (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire sgd_pkg::grad_word_t in_word,
    output logic                out_valid,
    input  wire logic           out_ready,
    output sgd_pkg::angle_word_t out_word
);
    import sgd_pkg::*;

    localparam int N = CORDIC_STAGES;

    // Stage 0 is the setup stage; stage k+1 holds the result of iteration k.
    logic                       valid_reg [0:N];
    logic                       stage_ready [0:N+1];
    logic signed [CORDIC_W-1:0] x_reg [0:N];
    logic signed [CORDIC_W-1:0] y_reg [0:N];
    logic signed [ANG_W-1:0]    z_reg [0:N];
    logic                       fixed_reg [0:N];
    logic signed [GRAD_W-1:0]   gx_reg [0:N];
    logic signed [GRAD_W-1:0]   gy_reg [0:N];
    logic                       border_reg [0:N];

    logic signed [CORDIC_W-1:0] gx_ext;
    logic signed [CORDIC_W-1:0] gy_ext;
    logic signed [CORDIC_W-1:0] x_next;
    logic signed [CORDIC_W-1:0] y_next;
    logic signed [ANG_W-1:0]    z_next;
    logic                       fixed_next;

    // A stage takes a new word when it is empty or its successor takes its own.
    assign stage_ready[N+1] = out_ready;
    generate
        for (genvar k = 0; k <= N; k++)
        begin : g_ready
            assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    endgenerate
    assign in_ready = stage_ready[0];

    // Setup: axis cases get their angle directly, the left half-plane is
    // mirrored with an offset of plus or minus pi, then the vector is scaled up.
    always_comb
    begin
        gx_ext     = CORDIC_W'(in_word.gx);
        gy_ext     = CORDIC_W'(in_word.gy);
        x_next     = gx_ext <<< PRESHIFT;
        y_next     = gy_ext <<< PRESHIFT;
        z_next     = ANG_ZERO;
        fixed_next = 1'b0;
        priority if (in_word.gx == '0 && in_word.gy == '0)
        begin
            fixed_next = 1'b1;
        end
        else if (in_word.gy == '0)
        begin
            fixed_next = 1'b1;
            z_next     = (in_word.gx > 0) ? ANG_ZERO : ANG_PI;
        end
        else if (in_word.gx == '0)
        begin
            fixed_next = 1'b1;
            z_next     = (in_word.gy > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
        end
        else if (in_word.gx < 0)
        begin
            z_next = (in_word.gy >= 0) ? ANG_PI : -ANG_PI;
            x_next = (-gx_ext) <<< PRESHIFT;
            y_next = (-gy_ext) <<< PRESHIFT;
        end
        else
        begin
            z_next = ANG_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (stage_ready[0])
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && in_valid)
        begin
            x_reg[0]      <= x_next;
            y_reg[0]      <= y_next;
            z_reg[0]      <= z_next;
            fixed_reg[0]  <= fixed_next;
            gx_reg[0]     <= in_word.gx;
            gy_reg[0]     <= in_word.gy;
            border_reg[0] <= in_word.border;
        end
    end

    // Iteration k rotates toward the x axis by atan(2^-k); the arithmetic
    // shift floors, as the angle accumulation expects.
    generate
        for (genvar k = 0; k < N; k++)
        begin : g_iter
            localparam logic signed [ANG_W-1:0] STEP_ANG = atan_q13(k);

            logic signed [CORDIC_W-1:0] x_it;
            logic signed [CORDIC_W-1:0] y_it;
            logic signed [ANG_W-1:0]    z_it;

            always_comb
            begin
                if (fixed_reg[k])
                begin
                    x_it = x_reg[k];
                    y_it = y_reg[k];
                    z_it = z_reg[k];
                end
                else if (y_reg[k] >= 0)
                begin
                    x_it = x_reg[k] + (y_reg[k] >>> k);
                    y_it = y_reg[k] - (x_reg[k] >>> k);
                    z_it = z_reg[k] + STEP_ANG;
                end
                else
                begin
                    x_it = x_reg[k] - (y_reg[k] >>> k);
                    y_it = y_reg[k] + (x_reg[k] >>> k);
                    z_it = z_reg[k] - STEP_ANG;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else if (stage_ready[k+1])
                begin
                    valid_reg[k+1] <= valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k+1] && valid_reg[k])
                begin
                    x_reg[k+1]      <= x_it;
                    y_reg[k+1]      <= y_it;
                    z_reg[k+1]      <= z_it;
                    fixed_reg[k+1]  <= fixed_reg[k];
                    gx_reg[k+1]     <= gx_reg[k];
                    gy_reg[k+1]     <= gy_reg[k];
                    border_reg[k+1] <= border_reg[k];
                end
            end
        end
    endgenerate

    assign out_valid       = valid_reg[N];
    assign out_word.angle  = z_reg[N];
    assign out_word.gx     = gx_reg[N];
    assign out_word.gy     = gy_reg[N];
    assign out_word.border = border_reg[N];

endmodule

`default_nettype wire

// ===== rtl/scharr_gradient_direction.sv =====
// Top level of the Scharr gradient direction block: configuration registers,
// gradient stage, CORDIC pipeline and output register. Depends on sgd_pkg.
//
// Usage:
//   Input words (coordinates and eight neighbours) arrive on in_valid/in_ready,
//   one result word leaves on out_valid/out_ready for every input word, in order.
//   The image size is written through cfg_valid/cfg_ready with cfg_index
//   selecting width (0) or height (1); cfg_ready is always high. Write it only
//   while no words are in flight.
//   Words pass through one gradient stage, one CORDIC setup stage, one stage
//   per CORDIC iteration and the output register. Unless out_ready stalls the
//   pipeline, a new word can enter on every cycle, so throughput is one word
//   per cycle; the pipeline depth is set by the CORDIC iteration count.
//   Every stage has its own valid bit and takes a word when it is empty or its
//   successor moves, so a stall on out_ready fills the empty stages first and
//   only then lowers in_ready; nothing is dropped or duplicated.
//   Reset empties the pipeline and sets the image size to 640 by 480.
`default_nettype none

module scharr_gradient_direction (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [sgd_pkg::COORD_W-1:0]       x_coord,
    input  wire logic [sgd_pkg::COORD_W-1:0]       y_coord,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_top_left,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_top_mid,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_top_right,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_mid_left,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_mid_right,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_bot_left,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_bot_mid,
    input  wire logic [sgd_pkg::PIX_W-1:0]         pixel_bot_right,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [sgd_pkg::DIR_W-1:0]       direction,
    output logic signed [sgd_pkg::GRAD_W-1:0]      grad_horizontal,
    output logic signed [sgd_pkg::GRAD_W-1:0]      grad_vertical,
    output logic                                   at_border,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sgd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sgd_pkg::DIM_W-1:0]         cfg_data
);
    import sgd_pkg::*;

    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic                    grad_valid;
    logic                    grad_ready;
    grad_word_t              grad_word;
    logic                    cordic_valid;
    logic                    cordic_ready;
    angle_word_t             cordic_word;
    logic signed [ANG_W-1:0] angle_clamped;
    logic                    out_valid_reg;
    logic signed [DIR_W-1:0] direction_reg;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    logic                    border_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    sgd_grad u_grad (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .pixel_top_left  (pixel_top_left),
        .pixel_top_mid   (pixel_top_mid),
        .pixel_top_right (pixel_top_right),
        .pixel_mid_left  (pixel_mid_left),
        .pixel_mid_right (pixel_mid_right),
        .pixel_bot_left  (pixel_bot_left),
        .pixel_bot_mid   (pixel_bot_mid),
        .pixel_bot_right (pixel_bot_right),
        .image_width     (width_reg),
        .image_height    (height_reg),
        .out_valid       (grad_valid),
        .out_ready       (grad_ready),
        .out_word        (grad_word)
    );

    sgd_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grad_valid),
        .in_ready  (grad_ready),
        .in_word   (grad_word),
        .out_valid (cordic_valid),
        .out_ready (cordic_ready),
        .out_word  (cordic_word)
    );

    // Hold the angle within plus or minus pi.
    always_comb
    begin
        priority if (cordic_word.angle > ANG_PI)
        begin
            angle_clamped = ANG_PI;
        end
        else if (cordic_word.angle < -ANG_PI)
        begin
            angle_clamped = -ANG_PI;
        end
        else
        begin
            angle_clamped = cordic_word.angle;
        end
    end

    // Output register.
    assign cordic_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cordic_ready)
        begin
            out_valid_reg <= cordic_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cordic_ready && cordic_valid)
        begin
            direction_reg <= angle_clamped[DIR_W-1:0];
            gx_reg        <= cordic_word.gx;
            gy_reg        <= cordic_word.gy;
            border_reg    <= cordic_word.border;
        end
    end

    assign out_valid       = out_valid_reg;
    assign direction       = direction_reg;
    assign grad_horizontal = gx_reg;
    assign grad_vertical   = gy_reg;
    assign at_border       = border_reg;

endmodule

`default_nettype wire

// ===== rtl/sgd_checker.sv =====
// Port-level checker for the Scharr gradient direction block and its bind.
// Depends on sgd_pkg and the top level scharr_gradient_direction.
`default_nettype none

module sgd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [sgd_pkg::DIR_W-1:0]  direction,
    input  wire logic signed [sgd_pkg::GRAD_W-1:0] grad_horizontal,
    input  wire logic signed [sgd_pkg::GRAD_W-1:0] grad_vertical,
    input  wire logic                          at_border
);
    import sgd_pkg::*;

    localparam logic signed [DIR_W-1:0] DIR_PI   = DIR_W'(ANG_PI);
    localparam logic signed [DIR_W-1:0] DIR_ZERO = '0;

    // A stalled result word holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(direction) &&
        $stable(grad_horizontal) && $stable(grad_vertical) && $stable(at_border))
        else $error("result word changed while stalled");

    // A border word carries zero gradients and a zero direction.
    a_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && at_border |-> direction == DIR_ZERO &&
        grad_horizontal == '0 && grad_vertical == '0)
        else $error("border word is not all zero");

    // The angle stays within plus or minus pi.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> direction <= DIR_PI && direction >= -DIR_PI)
        else $error("direction outside plus or minus pi");

    // A zero vertical gradient gives an angle of zero or pi.
    a_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grad_vertical == '0 |->
        (grad_horizontal < 0 && direction == DIR_PI) ||
        (grad_horizontal >= 0 && direction == DIR_ZERO))
        else $error("horizontal axis direction wrong");

endmodule

bind scharr_gradient_direction sgd_checker u_sgd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .direction       (direction),
    .grad_horizontal (grad_horizontal),
    .grad_vertical   (grad_vertical),
    .at_border       (at_border)
);

`default_nettype wire
